// ===== rtl/smsd_pkg.sv =====
// ----------------------------------------------------------------------------
// smsd_pkg: shared constants and types for the sliding median spike detector
// Defaults for the top-level parameters, register widths and the control
// struct broadcast from the sequencer to the sorted cell chain.
// ----------------------------------------------------------------------------
package smsd_pkg;

    localparam int WINDOW_MAX_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int          LEN_BITS   = 7;
    localparam int          COUNT_BITS = 32;
    localparam logic [6:0]  LEN_RESET  = 7'd5;

    // per-cycle command to every cell of the chain
    typedef struct packed {
        logic remove;   // drop the oldest entry, upper entries move down
        logic insert;   // insert the new sample, upper entries move up
    } cell_ctrl_t;

endpackage

// ===== rtl/smsd_if.sv =====
// ----------------------------------------------------------------------------
// smsd interfaces: valid/ready channels of the spike detector
// Sample input channel, result output channel and window length write port.
// ----------------------------------------------------------------------------
interface smsd_in_if #(
    parameter int SAMPLE_BITS = smsd_pkg::SAMPLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   restart;

    modport source (output valid, output sample, output restart, input ready);
    modport sink   (input valid, input sample, input restart, output ready);
endinterface

interface smsd_out_if;
    logic                            valid;
    logic                            ready;
    logic                            judged;
    logic                            alert;
    logic [smsd_pkg::COUNT_BITS-1:0] alert_count;

    modport source (output valid, output judged, output alert, output alert_count,
                    input ready);
    modport sink   (input valid, input judged, input alert, input alert_count,
                    output ready);
endinterface

interface smsd_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [smsd_pkg::LEN_BITS-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/sliding_median_spike_detector_top.sv =====
// ----------------------------------------------------------------------------
// sliding_median_spike_detector_top: running median spike detector
// Flags samples at or above twice the median of the preceding window.
// ----------------------------------------------------------------------------
// usage:
//   samples : one transaction per sample (sample, restart)
//   results : one transaction per sample (judged, alert, alert_count)
//   cfg     : writes window_len (clamped to 1..WINDOW_MAX) and empties the
//             window; write only while the block is idle
// the window is a chain of WINDOW_MAX sorted cells. each item has a remove
// step, which judges against the median and drops the oldest entry, then an
// insert step, which inserts the new sample. the result register is loaded
// in the insert step; the next sample is taken in that same step, so a new
// sample is accepted only while idle or in the insert step of the last one.
// if results stalls, the insert cycle waits until the output register frees,
// and samples is held off meanwhile. reset empties the window, clears the
// alert count and sets window_len to 5; cell contents are not reset.
// ----------------------------------------------------------------------------
module sliding_median_spike_detector_top #(
    parameter int WINDOW_MAX  = smsd_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = smsd_pkg::SAMPLE_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    smsd_cfg_if.sink      cfg,
    smsd_in_if.sink       samples,
    smsd_out_if.source    results
);

    localparam int SB = SAMPLE_BITS;
    localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CW = $clog2(WINDOW_MAX + 1) + 1;
    localparam int NB = smsd_pkg::COUNT_BITS;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_REMOVE = 2'd1;
    localparam logic [1:0] ST_INSERT = 2'd2;

    logic [1:0]                      state_reg, state_next;
    logic [smsd_pkg::LEN_BITS-1:0]   len_reg;
    logic [CW-1:0]                   fill_reg;
    logic [CW-1:0]                   ins_n_reg;
    logic [NB-1:0]                   count_reg;
    logic [SB-1:0]                   s_reg;
    logic                            restart_reg;
    logic                            judged_reg;
    logic                            alert_reg;

    logic                            out_valid_reg;
    logic                            out_judged_reg;
    logic                            out_alert_reg;
    logic [NB-1:0]                   out_count_reg;

    logic            out_free;
    logic            in_take;
    logic [31:0]     len32;
    logic [CW-1:0]   eff_len;
    logic [CW-1:0]   eff_fill;
    logic            full;
    logic [CW-1:0]   mid;
    logic [SB-1:0]   med_hi;
    logic [SB-1:0]   med_lo;
    logic [SB:0]     thr;
    logic            hit;
    logic [CW-1:0]   cell_n;
    logic [AW-1:0]   oldest_age;
    logic [SB-1:0]   v_old;

    smsd_pkg::cell_ctrl_t ctrl;

    logic [SB-1:0] cell_val    [WINDOW_MAX];
    logic [AW-1:0] cell_age    [WINDOW_MAX];
    logic          cell_ge     [WINDOW_MAX];
    logic          cell_oldest [WINDOW_MAX];

    // effective window length
    assign len32 = 32'(len_reg);
    always_comb
    begin
        if (len32 == 32'd0)
            eff_len = CW'(1);
        else if (len32 > 32'(WINDOW_MAX))
            eff_len = CW'(WINDOW_MAX);
        else
            eff_len = CW'(len32);
    end

    assign eff_fill   = restart_reg ? '0 : fill_reg;
    assign full       = (eff_fill == eff_len);
    assign oldest_age = AW'(eff_len - CW'(1));
    assign cell_n     = (state_reg == ST_REMOVE) ? eff_len : ins_n_reg;

    // median threshold, exact integer of SB+1 bits
    assign mid    = eff_len >> 1;
    assign med_hi = cell_val[mid[AW-1:0]];
    assign med_lo = cell_val[AW'(mid - CW'(1))];
    assign thr    = eff_len[0] ? {med_hi, 1'b0} : ({1'b0, med_hi} + {1'b0, med_lo});
    assign hit    = full && ({1'b0, s_reg} >= thr);

    // value of the oldest entry, one-hot select over the chain
    always_comb
    begin
        v_old = '0;
        for (int i = 0; i < WINDOW_MAX; i++)
        begin
            if (cell_oldest[i])
                v_old = v_old | cell_val[i];
        end
    end

    assign out_free = !out_valid_reg || results.ready;
    assign samples.ready = (state_reg == ST_IDLE) ||
                           ((state_reg == ST_INSERT) && out_free);
    assign in_take = samples.valid && samples.ready;
    assign cfg.ready = 1'b1;

    assign ctrl.remove = (state_reg == ST_REMOVE) && full;
    assign ctrl.insert = (state_reg == ST_INSERT) && out_free;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                    state_next = ST_REMOVE;
            end
            ST_REMOVE:
            begin
                state_next = ST_INSERT;
            end
            ST_INSERT:
            begin
                if (out_free)
                    state_next = in_take ? ST_REMOVE : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_reg       <= smsd_pkg::LEN_RESET;
            fill_reg      <= '0;
            ins_n_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid && cfg.ready)
            begin
                len_reg  <= cfg.data;
                fill_reg <= '0;
            end
            else if (state_reg == ST_REMOVE)
            begin
                fill_reg  <= full ? eff_fill : eff_fill + CW'(1);
                ins_n_reg <= full ? eff_fill - CW'(1) : eff_fill;
                if (restart_reg)
                    count_reg <= hit ? NB'(1) : '0;
                else if (hit && (count_reg != {NB{1'b1}}))
                    count_reg <= count_reg + NB'(1);
            end
            if (ctrl.insert)
                out_valid_reg <= 1'b1;
            else if (results.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s_reg       <= samples.sample;
            restart_reg <= samples.restart;
        end
        if (state_reg == ST_REMOVE)
        begin
            judged_reg <= full;
            alert_reg  <= hit;
        end
        if (ctrl.insert)
        begin
            out_judged_reg <= judged_reg;
            out_alert_reg  <= alert_reg;
            out_count_reg  <= count_reg;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.judged      = out_judged_reg;
    assign results.alert       = out_alert_reg;
    assign results.alert_count = out_count_reg;

    // sorted cell chain
    genvar g;
    generate
        for (g = 0; g < WINDOW_MAX; g++)
        begin : g_cell
            logic [SB-1:0] lv;
            logic [AW-1:0] la;
            logic          lg;
            logic [SB-1:0] rv;
            logic [AW-1:0] ra;

            if (g == 0)
            begin : g_first
                assign lv = '0;
                assign la = '0;
                assign lg = 1'b0;
            end
            else
            begin : g_mid
                assign lv = cell_val[g-1];
                assign la = cell_age[g-1];
                assign lg = cell_ge[g-1];
            end

            if (g == WINDOW_MAX - 1)
            begin : g_last
                assign rv = '0;
                assign ra = '0;
            end
            else
            begin : g_inner
                assign rv = cell_val[g+1];
                assign ra = cell_age[g+1];
            end

            smsd_cell #(
                .IDX (g),
                .SB  (SB),
                .AW  (AW),
                .CW  (CW)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .s          (s_reg),
                .v_old      (v_old),
                .oldest_age (oldest_age),
                .n          (cell_n),
                .left_val   (lv),
                .left_age   (la),
                .left_ge    (lg),
                .right_val  (rv),
                .right_age  (ra),
                .val        (cell_val[g]),
                .age        (cell_age[g]),
                .ge         (cell_ge[g]),
                .oldest     (cell_oldest[g])
            );
        end
    endgenerate

endmodule

// ===== rtl/smsd_cell.sv =====
// ----------------------------------------------------------------------------
// smsd_cell: one slot of the sorted window
// Holds a sample value and its age; moves down on remove, up on insert.
// Entries are ordered by value, and among equal values by age.
// ----------------------------------------------------------------------------
module smsd_cell #(
    parameter int IDX = 0,
    parameter int SB  = smsd_pkg::SAMPLE_BITS_DEF,
    parameter int AW  = 6,
    parameter int CW  = 7
) (
    input  logic                 clk,
    input  smsd_pkg::cell_ctrl_t ctrl,
    input  logic [SB-1:0]        s,
    input  logic [SB-1:0]        v_old,
    input  logic [AW-1:0]        oldest_age,
    input  logic [CW-1:0]        n,
    input  logic [SB-1:0]        left_val,
    input  logic [AW-1:0]        left_age,
    input  logic                 left_ge,
    input  logic [SB-1:0]        right_val,
    input  logic [AW-1:0]        right_age,
    output logic [SB-1:0]        val,
    output logic [AW-1:0]        age,
    output logic                 ge,
    output logic                 oldest
);

    localparam logic [CW-1:0] IDX_C = CW'(IDX);

    logic [SB-1:0] val_reg, val_next;
    logic [AW-1:0] age_reg, age_next;
    logic          in_use;

    assign in_use = IDX_C < n;
    assign oldest = in_use && (age_reg == oldest_age);
    // insertion point: new sample goes in front of entries not below it
    assign ge     = in_use && (val_reg >= s);

    always_comb
    begin
        val_next = val_reg;
        age_next = age_reg;
        if (ctrl.remove)
        begin
            if (in_use && (oldest || (val_reg > v_old)))
            begin
                val_next = right_val;
                age_next = right_age;
            end
        end
        else if (ctrl.insert)
        begin
            if (left_ge)
            begin
                val_next = left_val;
                age_next = left_age + AW'(1);
            end
            else if (ge || (IDX_C == n))
            begin
                val_next = s;
                age_next = '0;
            end
            else if (in_use)
            begin
                age_next = age_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        age_reg <= age_next;
    end

    assign val = val_reg;
    assign age = age_reg;

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for sliding_median_spike_detector_top
// Directed and random samples go in over the sample channel. A predictor
// keeps its own sorted window and arrival ring and works out each verdict
// (judged, alert, alert count). Every result transaction is checked
// against the oldest pending verdict. Window length writes happen only
// while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int WMAX  = smsd_pkg::WINDOW_MAX_DEF;
    localparam int SBITS = smsd_pkg::SAMPLE_BITS_DEF;
    localparam int CBITS = smsd_pkg::COUNT_BITS;
    localparam int LBITS = smsd_pkg::LEN_BITS;

    typedef struct packed {
        logic             judged;
        logic             alert;
        logic [CBITS-1:0] count;
    } verdict_t;

    logic clk;
    logic rst_n;

    smsd_cfg_if                         cfg_if ();
    smsd_in_if #(.SAMPLE_BITS(SBITS))   samp_if ();
    smsd_out_if                         res_if ();

    sliding_median_spike_detector_top #(
        .WINDOW_MAX  (WMAX),
        .SAMPLE_BITS (SBITS)
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_if),
        .samples (samp_if),
        .results (res_if)
    );

    // predictor state
    logic [SBITS-1:0]      win_sorted [0:WMAX-1];
    logic [SBITS-1:0]      win_ring   [0:WMAX-1];
    int                    ring_pos;
    int                    held;
    logic [CBITS-1:0]      alert_total;
    logic [LBITS-1:0]      len_reg;

    verdict_t pending_verdicts [$];
    int       mismatches;
    int       send_idle_pct;
    int       recv_stall_pct;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5000000;
        $display("FAIL sliding_median_spike_detector_top");
        $finish;
    end

    always @(posedge clk)
    begin
        res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic int active_len();
        if (len_reg == 0)
            return 1;
        if (len_reg > WMAX)
            return WMAX;
        return int'(len_reg);
    endfunction

    task automatic place_sorted(input int n, input logic [SBITS-1:0] s);
        int k;
        k = n;
        while (k > 0 && win_sorted[k-1] > s)
        begin
            win_sorted[k] = win_sorted[k-1];
            k--;
        end
        win_sorted[k] = s;
    endtask

    // verdict for one accepted sample, then window update
    task automatic judge_sample(input logic [SBITS-1:0] s, input logic r);
        int           n;
        int           k;
        int           mid;
        logic [SBITS:0] thr;
        verdict_t     v;
        n = active_len();
        v = '0;
        if (r)
        begin
            held        = 0;
            ring_pos    = 0;
            alert_total = '0;
        end
        if (held > n)
        begin
            held     = 0;
            ring_pos = 0;
        end
        if (held == n)
        begin
            mid = n / 2;
            if (n % 2 != 0)
                thr = {win_sorted[mid], 1'b0};
            else
                thr = {1'b0, win_sorted[mid]} + {1'b0, win_sorted[mid-1]};
            v.judged = 1'b1;
            if ({1'b0, s} >= thr)
            begin
                v.alert = 1'b1;
                if (alert_total != '1)
                    alert_total++;
            end
            if (ring_pos >= n)
                ring_pos = 0;
            // drop the oldest sample from the sorted window
            k = 0;
            while (k < n && win_sorted[k] != win_ring[ring_pos])
                k++;
            if (k >= n)
                k = n - 1;
            while (k + 1 < n)
            begin
                win_sorted[k] = win_sorted[k+1];
                k++;
            end
            place_sorted(n - 1, s);
            win_ring[ring_pos] = s;
            ring_pos = (ring_pos + 1) % n;
        end
        else
        begin
            place_sorted(held, s);
            win_ring[held] = s;
            held++;
            ring_pos = 0;
        end
        v.count = alert_total;
        pending_verdicts = {pending_verdicts, v};
    endtask

    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $display("%0t: unexpected result transaction judged=%0b alert=%0b count=%0d",
                         $time, res_if.judged, res_if.alert, res_if.alert_count);
                mismatches++;
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (res_if.judged !== want.judged)
                begin
                    $display("%0t: judged expected %0b actual %0b",
                             $time, want.judged, res_if.judged);
                    mismatches++;
                end
                if (res_if.alert !== want.alert)
                begin
                    $display("%0t: alert expected %0b actual %0b",
                             $time, want.alert, res_if.alert);
                    mismatches++;
                end
                if (res_if.alert_count !== want.count)
                begin
                    $display("%0t: alert_count expected %0d actual %0d",
                             $time, want.count, res_if.alert_count);
                    mismatches++;
                end
            end
        end
    end

    task automatic send_sample(input logic [SBITS-1:0] s, input logic r);
        if ($urandom_range(99) < send_idle_pct)
        begin
            samp_if.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        samp_if.valid   <= 1'b1;
        samp_if.sample  <= s;
        samp_if.restart <= r;
        @(posedge clk);
        while (!samp_if.ready)
            @(posedge clk);
        judge_sample(s, r);
    endtask

    task automatic drain();
        samp_if.valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // a write empties the window, the count is kept
    task automatic write_window_len(input logic [LBITS-1:0] v);
        drain();
        cfg_if.data  <= v;
        cfg_if.valid <= 1'b1;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        cfg_if.valid <= 1'b0;
        len_reg  = v;
        held     = 0;
        ring_pos = 0;
    endtask

    // values around the window level, spikes near the threshold, and noise
    function automatic logic [SBITS-1:0] make_sample(input int base);
        int r;
        int v;
        r = $urandom_range(99);
        if (r < 15)
            v = $urandom_range(65535);
        else if (r < 27)
            v = 2 * base + $urandom_range(4) - 2;
        else if (r < 31)
            v = ($urandom_range(1) != 0) ? 65535 : 0;
        else
            v = base + $urandom_range(base / 2 + 3) - (base / 4 + 1);
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return v[SBITS-1:0];
    endfunction

    task automatic test_default_window();
        // window of five after reset
        send_sample(16'd0, 1'b0);
        send_sample(16'd65535, 1'b0);
        send_sample(16'd100, 1'b0);
        send_sample(16'd200, 1'b0);
        send_sample(16'd300, 1'b0);
        send_sample(16'd400, 1'b0);
        send_sample(16'd599, 1'b0);
        send_sample(16'd65535, 1'b0);
    endtask

    task automatic test_length_clamp();
        // zero acts as one
        write_window_len(7'd0);
        send_sample(16'd10, 1'b0);
        send_sample(16'd20, 1'b0);
        send_sample(16'd39, 1'b0);
        // above the maximum acts as the maximum
        write_window_len(7'd127);
        send_sample(16'd5, 1'b0);
        send_sample(16'd65535, 1'b0);
        write_window_len(7'd65);
        send_sample(16'd1, 1'b0);
    endtask

    task automatic test_even_window();
        write_window_len(7'd2);
        send_sample(16'd3, 1'b0);
        send_sample(16'd5, 1'b0);
        send_sample(16'd8, 1'b0);
        send_sample(16'd12, 1'b0);
        // full scale window: threshold above any sample
        send_sample(16'd65535, 1'b0);
        send_sample(16'd65535, 1'b0);
        send_sample(16'd65535, 1'b0);
        // all zero window: everything alerts
        send_sample(16'd0, 1'b0);
        send_sample(16'd0, 1'b0);
        send_sample(16'd0, 1'b0);
    endtask

    task automatic test_restart();
        write_window_len(7'd3);
        send_sample(16'd7, 1'b0);
        send_sample(16'd8, 1'b0);
        send_sample(16'd9, 1'b0);
        send_sample(16'd100, 1'b0);
        send_sample(16'd1, 1'b1);
        send_sample(16'd2, 1'b0);
    endtask

    task automatic test_random_traffic(input int n_items);
        int                  sent;
        int                  seg;
        int                  r;
        int                  base;
        logic [LBITS-1:0]    len;
        sent = 0;
        while (sent < n_items)
        begin
            r = $urandom_range(99);
            if (r < 8)
                len = 7'd0;
            else if (r < 16)
                len = 7'd1;
            else if (r < 24)
                len = 7'd2;
            else if (r < 28)
                len = LBITS'($urandom_range(127, 65));
            else if (r < 31)
                len = 7'd64;
            else if (r < 34)
                len = 7'd63;
            else
                len = LBITS'($urandom_range(12, 3));
            write_window_len(len);
            seg  = active_len() + $urandom_range(30, 4);
            base = ($urandom_range(99) < 20) ? $urandom_range(15) : $urandom_range(32767, 16);
            repeat (seg)
            begin
                send_sample(make_sample(base), $urandom_range(99) < 3);
                sent++;
            end
        end
    endtask

    initial
    begin
        int i;
        rst_n           = 1'b0;
        samp_if.valid   = 1'b0;
        samp_if.sample  = '0;
        samp_if.restart = 1'b0;
        cfg_if.valid    = 1'b0;
        cfg_if.data     = '0;
        mismatches      = 0;
        len_reg         = smsd_pkg::LEN_RESET;
        held            = 0;
        ring_pos        = 0;
        alert_total     = '0;
        for (i = 0; i < WMAX; i++)
        begin
            win_sorted[i] = '0;
            win_ring[i]   = '0;
        end
        send_idle_pct  = 33;
        recv_stall_pct = 53;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_window();
        test_length_clamp();
        test_even_window();
        test_restart();
        test_random_traffic(230);

        send_idle_pct  = 53;
        recv_stall_pct = 33;
        test_random_traffic(230);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random_traffic(230);

        drain();
        if (mismatches == 0)
            $display("PASS sliding_median_spike_detector_top");
        else
            $display("FAIL sliding_median_spike_detector_top");
        $finish;
    end

endmodule
